FILE: sv/ordered_list_indexed_insert_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block
// Concurrent checks on clk, disabled while rst is high; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INDEXED_INSERT_DEFINES_SVH
`define ORDERED_LIST_INDEXED_INSERT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define OLII_ASSERT_NOW(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("olii assertion failed");

// Next-cycle implication
`define OLII_ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("olii assertion failed");

`else

`define OLII_ASSERT_NOW(name, cond, conseq)
`define OLII_ASSERT_NEXT(name, cond, conseq)

`endif

`endif

FILE: sv/olii_pkg.sv
// ----------------------------------------------------------------------------
// olii_pkg
// Types, codes and sizes shared by the ordered list cells and top level.
// ----------------------------------------------------------------------------
package olii_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic        [KIND_W-1:0] kind;
    logic        [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [STAT_W-1:0] status;
    logic        [CNT_W-1:0]  count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] read_value;
  } out_item_t;

endpackage

FILE: sv/olii_cell.sv
// ----------------------------------------------------------------------------
// olii_cell
// One slot of the list: holds an element, loads, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module olii_cell (
  input  logic                          clk,
  input  olii_pkg::cell_ctrl_t          ctrl,
  input  logic signed [olii_pkg::DATA_W-1:0] load_value,
  input  logic signed [olii_pkg::DATA_W-1:0] left_value,
  input  logic signed [olii_pkg::DATA_W-1:0] right_value,
  output logic signed [olii_pkg::DATA_W-1:0] value,
  output logic signed [olii_pkg::DATA_W-1:0] rd_value
);
  import olii_pkg::*;

  logic signed [DATA_W-1:0] value_next;

  always_comb begin
    case (ctrl.op)
      CELL_LOAD:  value_next = load_value;
      CELL_LEFT:  value_next = left_value;
      CELL_RIGHT: value_next = right_value;
      default:    value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Masked read-out; the top level ORs all lanes together.
  assign rd_value = ctrl.rd_sel ? value : '0;

endmodule

FILE: sv/ordered_list_indexed_insert.sv
// ----------------------------------------------------------------------------
// ordered_list_indexed_insert: result valid is registered after an accepted input.
// One transaction per cycle unless out_ready stalls; every op is one cell-row step.
// Sync active-high rst empties the list (count zero); element slots are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_indexed_insert (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  olii_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output olii_pkg::out_item_t out_data
);
  import olii_pkg::*;

`include "ordered_list_indexed_insert_defines.svh"

  // Element count; slots at and above it hold stale data and are never read.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             in_acc;
  logic             full;
  logic             empty;
  logic             do_insert;
  logic             do_pop_front;
  logic             do_pop_back;
  logic             rd_ok;
  logic [CNT_W-1:0] ins_pos;
  logic [STAT_W-1:0] status;

  logic signed [DATA_W-1:0] lane_val [CAPACITY];
  logic signed [DATA_W-1:0] lane_rd  [CAPACITY];
  logic signed [DATA_W-1:0] rd_any;

  // Output register frees the input side whenever the result is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign full  = (count >= CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // Operation decode. Fullness is checked before the insert position.
  always_comb begin
    do_insert    = 1'b0;
    do_pop_front = 1'b0;
    do_pop_back  = 1'b0;
    rd_ok        = 1'b0;
    ins_pos      = '0;
    status       = ST_OK;
    case (in_data.kind)
      KIND_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else      do_insert = 1'b1;
      end
      KIND_PUSH_BACK: begin
        ins_pos = count;
        if (full) status = ST_FULL;
        else      do_insert = 1'b1;
      end
      KIND_POP_FRONT: begin
        if (empty) status = ST_EMPTY;
        else       do_pop_front = 1'b1;
      end
      KIND_POP_BACK: begin
        if (empty) status = ST_EMPTY;
        else       do_pop_back = 1'b1;
      end
      KIND_INSERT: begin
        ins_pos = in_data.position;
        if (full)                          status = ST_FULL;
        else if (in_data.position > count) status = ST_RANGE;
        else                               do_insert = 1'b1;
      end
      KIND_READ: begin
        if (in_data.position >= count) status = ST_RANGE;
        else                           rd_ok = 1'b1;
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (in_acc && do_insert) begin
      count_next = count + 1'b1;
    end else if (in_acc && (do_pop_front || do_pop_back)) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Cell row. Insert: slots above the position take their left neighbor,
  // the slot at the position loads the new value. Pop front: every slot
  // takes its right neighbor. Pop back only drops the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_lane
    localparam logic [CNT_W-1:0] LANE = CNT_W'(i);

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_mid_l
      assign left_value = lane_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = lane_val[i+1];
    end

    always_comb begin
      ctrl.op     = CELL_HOLD;
      ctrl.rd_sel = in_acc && rd_ok && (in_data.position == LANE);
      if (in_acc && do_insert) begin
        if (LANE == ins_pos)     ctrl.op = CELL_LOAD;
        else if (LANE > ins_pos) ctrl.op = CELL_LEFT;
      end else if (in_acc && do_pop_front) begin
        ctrl.op = CELL_RIGHT;
      end
    end

    olii_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .load_value  (in_data.value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (lane_val[i]),
      .rd_value    (lane_rd[i])
    );
  end

  // At most one lane is selected, so an OR gathers the read data
  // (zero when nothing is read).
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | lane_rd[k];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data.status     <= status;
      out_data.count      <= count_next;
      out_data.is_empty   <= (count_next == '0);
      out_data.read_value <= rd_any;
    end
  end

  // Checks
  `OLII_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(CAPACITY))
  `OLII_ASSERT_NEXT(a_count_idle, !in_acc, $stable(count))
  `OLII_ASSERT_NEXT(a_result_follows, in_acc, out_valid)
  `OLII_ASSERT_NOW(a_empty_flag, out_valid, out_data.is_empty == (out_data.count == '0))
  `OLII_ASSERT_NOW(a_read_zero, out_valid && (out_data.status != ST_OK), out_data.read_value == '0)

endmodule

FILE: tb/sv/ordered_list_indexed_insert_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_indexed_insert_tb
// Drives mixed push, pop, insert and read transactions into the bounded list
// and checks every reply, field by field, against a shadow copy of the list.
// The random part swings the list between empty and full so that the full,
// empty and out-of-range cases are hit repeatedly. It runs under four
// handshake phases: free flow, a slow sender, a stalling receiver, and both
// sides idling lightly.
// ----------------------------------------------------------------------------
module ordered_list_indexed_insert_tb;
  import olii_pkg::*;

  // Kind codes that the block treats as no operation.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 4;
  localparam int EDGE_VISITS     = 4;   // full/empty hits before the swing turns

  // --------------------------------------------------------------------------
  // Shadow list: holds the expected contents and count, predicts one reply per
  // accepted transaction and matches replies in order.
  // --------------------------------------------------------------------------
  class list_mirror;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    logic        [CNT_W-1:0]  held;
    out_item_t                pending_replies [$];
    int                       mismatches;
    int                       replies_checked;
    int                       status_seen [4];

    function new();
      held = '0;
      mismatches = 0;
      replies_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Shift the tail up one slot and drop the value into the gap.
    function void open_slot(int at, logic signed [DATA_W-1:0] v);
      for (int i = int'(held); i > at; i--) slots[i] = slots[i-1];
      slots[at] = v;
      held++;
    endfunction

    // Close the gap at 'at' by shifting the tail down.
    function void close_slot(int at);
      for (int i = at; i + 1 < int'(held); i++) slots[i] = slots[i+1];
      held--;
    endfunction

    // Apply one transaction to the shadow list and queue its reply.
    function void note_op(in_item_t op);
      out_item_t r;
      r = '0;
      r.status = ST_OK;
      case (op.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (held >= CAPACITY) r.status = ST_FULL;
          else open_slot((op.kind == KIND_PUSH_FRONT) ? 0 : int'(held), op.value);
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (held == 0) r.status = ST_EMPTY;
          else close_slot((op.kind == KIND_POP_FRONT) ? 0 : int'(held) - 1);
        end
        KIND_INSERT: begin
          // fullness wins over a bad position
          if (held >= CAPACITY) r.status = ST_FULL;
          else if (op.position > held) r.status = ST_RANGE;
          else open_slot(int'(op.position), op.value);
        end
        KIND_READ: begin
          if (op.position >= held) r.status = ST_RANGE;
          else r.read_value = slots[op.position];
        end
        default: ;
      endcase
      r.count    = held;
      r.is_empty = (held == 0);
      status_seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("[%0t] mismatch on reply %0d: %s", $time, replies_checked, what);
      mismatches++;
    endtask

    task check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("reply with nothing pending (%p)", got));
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.count !== want.count)
        flag_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      if (got.is_empty !== want.is_empty)
        flag_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
      if (got.read_value !== want.read_value)
        flag_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
      replies_checked++;
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  list_mirror mirror = new();

  // Handshake pressure of the current phase, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  ordered_list_indexed_insert u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: check the reply taken at this edge, then pick next cycle's ready.
  // out_ready read here is the value the block saw at the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) mirror.check_reply(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Sender: optional idle cycles, then hold valid until the block takes it.
  // The shadow list is updated right here so the next random transaction sees
  // the count that includes this one.
  task automatic send_op(input in_item_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_op(op);
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] kind,
                             input logic [POS_W-1:0] position,
                             input logic signed [DATA_W-1:0] value);
    in_item_t op;
    op.kind     = kind;
    op.position = position;
    op.value    = value;
    send_op(op);
  endtask

  // Random transaction biased toward growth or shrinkage; insert and read
  // positions mostly land inside the legal range, the rest anywhere.
  function automatic in_item_t random_op(bit growing, int count_now);
    in_item_t op;
    int       roll;
    roll        = $urandom_range(0, 99);
    op.position = POS_W'($urandom_range(0, 127));
    op.value    = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: op.value = 32'sh7FFF_FFFF;
        1: op.value = 32'sh8000_0000;
        2: op.value = '0;
        default: op.value = '1;
      endcase
    end
    if (growing) begin
      if      (roll < 25) op.kind = KIND_PUSH_FRONT;
      else if (roll < 50) op.kind = KIND_PUSH_BACK;
      else if (roll < 70) op.kind = KIND_INSERT;
      else if (roll < 85) op.kind = KIND_READ;
      else if (roll < 92) op.kind = KIND_POP_FRONT;
      else if (roll < 98) op.kind = KIND_POP_BACK;
      else op.kind = roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
    end else begin
      if      (roll < 5)  op.kind = KIND_PUSH_FRONT;
      else if (roll < 10) op.kind = KIND_PUSH_BACK;
      else if (roll < 15) op.kind = KIND_INSERT;
      else if (roll < 35) op.kind = KIND_READ;
      else if (roll < 65) op.kind = KIND_POP_FRONT;
      else if (roll < 95) op.kind = KIND_POP_BACK;
      else op.kind = roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
    end
    if ($urandom_range(0, 99) < 85) begin
      if (op.kind == KIND_INSERT)
        op.position = POS_W'($urandom_range(0, count_now));
      else if (op.kind == KIND_READ && count_now > 0)
        op.position = POS_W'($urandom_range(0, count_now - 1));
    end
    return op;
  endfunction

  initial begin
    bit growing;
    int edge_hits;
    int total_ops;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: empty list, boundaries of position, value extremes ----
    send_fields(KIND_READ,      7'd0,   32'sd5);          // read of empty list
    send_fields(KIND_POP_FRONT, 7'd0,   32'sd0);          // pop on empty
    send_fields(KIND_POP_BACK,  7'd0,   32'sd0);
    send_fields(KIND_INSERT,    7'd1,   32'sd9);          // insert past end, empty
    send_fields(KIND_PUSH_BACK, 7'd0,   32'sh7FFF_FFFF);  // push back onto empty
    send_fields(KIND_PUSH_FRONT, 7'd0,  32'sh8000_0000);
    send_fields(KIND_INSERT,    7'd2,   -32'sd1);         // position == count appends
    send_fields(KIND_INSERT,    7'd1,   32'sd0);          // middle insert
    send_fields(KIND_INSERT,    7'd127, 32'sd1);          // far past the end
    send_fields(KIND_INSERT,    7'd64,  32'sd1);
    for (int i = 0; i < 4; i++) send_fields(KIND_READ, POS_W'(i), 32'sd0);
    send_fields(KIND_READ,      7'd4,   32'sd0);          // read at count
    send_fields(KIND_READ,      7'd127, 32'sd0);
    send_fields(KIND_SPARE_LO,  7'd127, '1);              // unused kinds
    send_fields(KIND_SPARE_HI,  7'd0,   32'sd0);
    send_fields(KIND_POP_FRONT, 7'd0,   32'sd0);
    send_fields(KIND_POP_BACK,  7'd0,   32'sd0);
    send_fields(KIND_READ,      7'd0,   32'sd0);
    send_fields(KIND_POP_BACK,  7'd0,   32'sd0);
    send_fields(KIND_POP_FRONT, 7'd0,   32'sd0);          // now empty again
    send_fields(KIND_READ,      7'd0,   32'sd0);
    total_ops = 24;

    // ---- random: swing between empty and full under each phase ----
    growing   = 1'b1;
    edge_hits = 0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // linger at full or empty a few transactions, then turn around
        if ((growing && mirror.held == CAPACITY) || (!growing && mirror.held == 0)) begin
          edge_hits++;
          if (edge_hits >= EDGE_VISITS) begin
            growing   = !growing;
            edge_hits = 0;
          end
        end
        send_op(random_op(growing, int'(mirror.held)));
        total_ops++;
      end
    end

    // ---- drain: all replies in, then quiet cycles ----
    in_valid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d transactions in %0d handshake phases, %0d replies checked",
             total_ops, NUM_PHASES, mirror.replies_checked);
    $display("statuses: %0d ok, %0d empty, %0d full, %0d out of range; %0d mismatches",
             mirror.status_seen[ST_OK], mirror.status_seen[ST_EMPTY],
             mirror.status_seen[ST_FULL], mirror.status_seen[ST_RANGE],
             mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("ordered_list_indexed_insert_tb OK");
    end else begin
      $display("ordered_list_indexed_insert_tb NOT OK");
    end
    $finish;
  end

  // Hard stop: far beyond the length of a normal run.
  initial begin
    #2_000_000;
    $display("timeout with %0d replies outstanding", mirror.pending_replies.size());
    $display("ordered_list_indexed_insert_tb NOT OK");
    $finish;
  end

endmodule
